>>> hdl/arlc_pkg.sv
// ----------------------------------------------------------------------------
// arlc_pkg
// Shared types and constants of the AT response line classifier.
// ----------------------------------------------------------------------------
package arlc_pkg;

  // Default line buffer size; the longest line holds LINE_BYTES - 1 characters.
  localparam int LINE_BYTES_DEF = 64;

  // Field widths of the item and result beats.
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int MS_W    = 32;
  localparam int RESP_W  = 16;
  localparam int STAT_W  = 2;

  // Reset value of the response capacity register.
  localparam logic [RESP_W-1:0] RESP_CAP_RESET = 16'd256;

  // Line control characters.
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // Reply words. The first character sits in the top byte.
  localparam int PREFIX_LEN = 10;
  localparam int PRE_IW     = 4;
  localparam int OK_LEN     = 2;
  localparam int ERROR_LEN  = 5;
  localparam logic [OK_LEN*8-1:0]     WORD_OK    = "OK";
  localparam logic [ERROR_LEN*8-1:0]  WORD_ERROR = "ERROR";
  localparam logic [PREFIX_LEN*8-1:0] WORD_CME   = "+CME ERROR";
  localparam logic [PREFIX_LEN*8-1:0] WORD_CMS   = "+CMS ERROR";

  // Input commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // Final status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_ERROR    = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Result kinds.
  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_item;
    logic    do_start;
    logic    do_tick;
    logic    wr_byte;
    logic    clr_len;
    logic    clr_active;
    logic    resp_add;
    logic    rd_clear;
    logic    rd_step;
    logic    load_sep;
    logic    load_char;
    logic    load_status;
    status_e fin_status;
  } arlc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             active;
    logic             byte_cr;
    logic             byte_lf;
    logic             line_full;
    logic             timeout_hit;
    logic             line_empty;
    logic             is_ok;
    logic             is_err;
    logic             cap_zero;
    logic             overflow;
    logic             resp_nonzero;
    logic             stream_last;
    logic             out_free;
  } arlc_stat_t;

endpackage

>>> hdl/arlc_in_if.sv
// ----------------------------------------------------------------------------
// arlc_in_if
// Item channel: command, received byte and reply deadline with valid/ready.
// ----------------------------------------------------------------------------
interface arlc_in_if import arlc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] rx_byte;
  logic [MS_W-1:0]   wait_ms;

  modport source (output valid, command, rx_byte, wait_ms, input ready);
  modport sink   (input valid, command, rx_byte, wait_ms, output ready);

endinterface

>>> hdl/arlc_out_if.sv
// ----------------------------------------------------------------------------
// arlc_out_if
// Result channel: response characters and final status with valid/ready.
// ----------------------------------------------------------------------------
interface arlc_out_if import arlc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] resp_char;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, kind, resp_char, status, last, input ready);
  modport sink   (input valid, kind, resp_char, status, last, output ready);

endinterface

>>> hdl/arlc_datapath.sv
// ----------------------------------------------------------------------------
// arlc_datapath
// Line memory, prefix registers, counters, timer and result register.
// ----------------------------------------------------------------------------
module arlc_datapath import arlc_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RESP_W-1:0] cfg_wdata_i,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic [MS_W-1:0]   wait_ms_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              kind_o,
  output logic [BYTE_W-1:0] resp_char_o,
  output logic [STAT_W-1:0] status_o,
  output logic              last_o,
  input  arlc_cmd_t         cmd_i,
  output arlc_stat_t        stat_o
);

  localparam int LEN_W = $clog2(LINE_BYTES);

  // Latched item.
  logic [CMD_W-1:0]  cmd_q;
  logic [BYTE_W-1:0] byte_q;
  logic [MS_W-1:0]   tmo_q;

  // Exchange state.
  logic              active_q, active_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [RESP_W-1:0] resp_q, resp_d;
  logic [MS_W-1:0]   elapsed_q, elapsed_d;
  logic [MS_W-1:0]   deadline_q, deadline_d;
  logic [RESP_W-1:0] cap_q;
  logic [LEN_W-1:0]  rd_q, rd_d;

  // Line storage: full line in memory, first characters also in registers.
  logic [BYTE_W-1:0] mem_q [LINE_BYTES];
  logic [BYTE_W-1:0] rdata_q;
  logic [BYTE_W-1:0] pre_q [PREFIX_LEN];

  // Result register.
  logic              out_valid_q;
  logic              kind_q;
  logic [BYTE_W-1:0] char_q;
  logic [STAT_W-1:0] status_q;
  logic              last_q;

  logic [MS_W-1:0]   elapsed_inc;
  logic [RESP_W-1:0] n_ext;
  logic [RESP_W+1:0] need;
  logic              out_free;
  logic              out_load;
  logic              m_ok, m_error, m_cme, m_cms;

  // Saturating millisecond count and the deadline compare.
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;

  // Line length widened to the response width.
  assign n_ext = {{(RESP_W-LEN_W){1'b0}}, len_q};
  assign need  = {2'b00, resp_q} + {2'b00, n_ext} + 18'd2;

  // Reply word matching on the prefix registers.
  always_comb begin
    m_ok    = 1'b1;
    m_error = 1'b1;
    m_cme   = 1'b1;
    m_cms   = 1'b1;
    for (int i = 0; i < OK_LEN; i++) begin
      m_ok = m_ok & (pre_q[i] == WORD_OK[8*(OK_LEN-1-i) +: 8]);
    end
    for (int i = 0; i < ERROR_LEN; i++) begin
      m_error = m_error & (pre_q[i] == WORD_ERROR[8*(ERROR_LEN-1-i) +: 8]);
    end
    for (int i = 0; i < PREFIX_LEN; i++) begin
      m_cme = m_cme & (pre_q[i] == WORD_CME[8*(PREFIX_LEN-1-i) +: 8]);
      m_cms = m_cms & (pre_q[i] == WORD_CMS[8*(PREFIX_LEN-1-i) +: 8]);
    end
  end

  // Status toward the controller.
  assign out_free = !out_valid_q || out_ready_i;
  always_comb begin
    stat_o.cmd          = cmd_q;
    stat_o.active       = active_q;
    stat_o.byte_cr      = (byte_q == CHAR_CR);
    stat_o.byte_lf      = (byte_q == CHAR_LF);
    stat_o.line_full    = (len_q >= LEN_W'(LINE_BYTES - 2));
    stat_o.timeout_hit  = (elapsed_inc > deadline_q);
    stat_o.line_empty   = (len_q == '0);
    stat_o.is_ok        = (len_q == LEN_W'(OK_LEN)) && m_ok;
    stat_o.is_err       = ((len_q == LEN_W'(ERROR_LEN)) && m_error)
                          || ((len_q >= LEN_W'(PREFIX_LEN)) && (m_cme || m_cms));
    stat_o.cap_zero     = (cap_q == '0);
    stat_o.overflow     = (need >= {2'b00, cap_q});
    stat_o.resp_nonzero = (resp_q != '0);
    stat_o.stream_last  = ({1'b0, rd_q} + {{LEN_W{1'b0}}, 1'b1}) == {1'b0, len_q};
    stat_o.out_free     = out_free;
  end

  // Next values of the exchange state.
  always_comb begin
    active_d   = active_q;
    len_d      = len_q;
    resp_d     = resp_q;
    elapsed_d  = elapsed_q;
    deadline_d = deadline_q;
    rd_d       = rd_q;
    if (cmd_i.do_start) begin
      active_d   = 1'b1;
      len_d      = '0;
      resp_d     = '0;
      elapsed_d  = '0;
      deadline_d = tmo_q;
    end
    if (cmd_i.do_tick) begin
      elapsed_d = elapsed_inc;
    end
    if (cmd_i.wr_byte) begin
      len_d = len_q + LEN_W'(1);
    end
    if (cmd_i.clr_len) begin
      len_d = '0;
    end
    if (cmd_i.clr_active) begin
      active_d = 1'b0;
    end
    if (cmd_i.resp_add) begin
      resp_d = resp_q + n_ext + {{(RESP_W-1){1'b0}}, (resp_q != '0)};
    end
    if (cmd_i.rd_clear) begin
      rd_d = '0;
    end else if (cmd_i.rd_step) begin
      rd_d = rd_q + LEN_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      len_q       <= '0;
      resp_q      <= '0;
      elapsed_q   <= '0;
      deadline_q  <= '0;
      cap_q       <= RESP_CAP_RESET;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q   <= active_d;
      len_q      <= len_d;
      resp_q     <= resp_d;
      elapsed_q  <= elapsed_d;
      deadline_q <= deadline_d;
      rd_q       <= rd_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      cmd_q  <= command_i;
      byte_q <= rx_byte_i;
      tmo_q  <= wait_ms_i;
    end
  end

  // Line memory with registered read, and the prefix registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      mem_q[len_q] <= byte_q;
    end
    rdata_q <= mem_q[rd_d];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (cmd_i.wr_byte && (len_q == LEN_W'(i))) begin
        pre_q[i] <= byte_q;
      end
    end
  end

  // Result register payload.
  assign out_load = cmd_i.load_sep || cmd_i.load_char || cmd_i.load_status;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_status) begin
      kind_q   <= KIND_STATUS;
      char_q   <= '0;
      status_q <= cmd_i.fin_status;
      last_q   <= 1'b0;
    end else if (cmd_i.load_sep) begin
      kind_q   <= KIND_CHAR;
      char_q   <= CHAR_LF;
      status_q <= ST_OK;
      last_q   <= 1'b0;
    end else if (cmd_i.load_char) begin
      kind_q   <= KIND_CHAR;
      char_q   <= rdata_q;
      status_q <= ST_OK;
      last_q   <= stat_o.stream_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign resp_char_o = char_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

>>> hdl/arlc_ctrl.sv
// ----------------------------------------------------------------------------
// arlc_ctrl
// Controller: takes items, sequences line evaluation and streaming.
// ----------------------------------------------------------------------------
module arlc_ctrl import arlc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  arlc_stat_t stat_i,
  output arlc_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_WAIT = 6'b000001,
    S_EXEC = 6'b000010,
    S_END  = 6'b000100,
    S_SEP  = 6'b001000,
    S_CHR  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e  state_q, state_d;
  status_e fin_q, fin_d;

  // Next state and datapath commands.
  always_comb begin
    state_d          = state_q;
    fin_d            = fin_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.fin_status = fin_q;
    unique case (state_q)
      S_WAIT: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_WAIT;
        if (stat_i.cmd == CMD_START) begin
          cmd_o.do_start = 1'b1;
        end else if (stat_i.active) begin
          unique case (stat_i.cmd)
            CMD_TICK: begin
              cmd_o.do_tick = 1'b1;
              if (stat_i.timeout_hit) begin
                cmd_o.clr_active = 1'b1;
                fin_d            = ST_TIMEOUT;
                state_d          = S_FIN;
              end
            end
            CMD_BYTE: begin
              if (stat_i.byte_lf) begin
                state_d = S_END;
              end else if (!stat_i.byte_cr) begin
                cmd_o.wr_byte = 1'b1;
                if (stat_i.line_full) begin
                  state_d = S_END;
                end
              end
            end
            default: begin
              state_d = S_WAIT;
            end
          endcase
        end
      end
      S_END: begin
        // Classify the finished line.
        priority if (stat_i.line_empty) begin
          state_d = S_WAIT;
        end else if (stat_i.is_ok) begin
          cmd_o.clr_len    = 1'b1;
          cmd_o.clr_active = 1'b1;
          fin_d            = ST_OK;
          state_d          = S_FIN;
        end else if (stat_i.is_err) begin
          cmd_o.clr_len    = 1'b1;
          cmd_o.clr_active = 1'b1;
          fin_d            = ST_ERROR;
          state_d          = S_FIN;
        end else if (stat_i.cap_zero) begin
          cmd_o.clr_len = 1'b1;
          state_d       = S_WAIT;
        end else if (stat_i.overflow) begin
          cmd_o.clr_len    = 1'b1;
          cmd_o.clr_active = 1'b1;
          fin_d            = ST_OVERFLOW;
          state_d          = S_FIN;
        end else begin
          cmd_o.resp_add = 1'b1;
          cmd_o.rd_clear = 1'b1;
          state_d        = stat_i.resp_nonzero ? S_SEP : S_CHR;
        end
      end
      S_SEP: begin
        if (stat_i.out_free) begin
          cmd_o.load_sep = 1'b1;
          state_d        = S_CHR;
        end
      end
      S_CHR: begin
        // One line character per beat; the memory read runs one ahead.
        if (stat_i.out_free) begin
          cmd_o.load_char = 1'b1;
          if (stat_i.stream_last) begin
            cmd_o.clr_len = 1'b1;
            state_d       = S_WAIT;
          end else begin
            cmd_o.rd_step = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.load_status = 1'b1;
          state_d           = S_WAIT;
        end
      end
      default: begin
        state_d = S_WAIT;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WAIT;
      fin_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

endmodule

>>> hdl/at_response_line_classifier.sv
// A timeout status beat is loaded in S_FIN after its tick is evaluated in S_EXEC;
// a line status beat after the ending item passes S_EXEC, S_END and S_FIN.
// A streamed line's first beat, the separator if any, follows S_EXEC and S_END;
// then one beat per cycle while the result channel is free, n characters plus
// the optional separator (one memory read per beat). No new item is taken
// until the last one is done. Reset: async, idle, cap 256.
// ----------------------------------------------------------------------------
// at_response_line_classifier
// Classifies modem AT replies byte by byte and streams response lines.
// ----------------------------------------------------------------------------
module at_response_line_classifier import arlc_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  arlc_in_if.sink           rx_item_i,
  arlc_out_if.source        result_o,
  input  logic              cfg_we_i,
  input  logic [RESP_W-1:0] cfg_wdata_i
);

  arlc_cmd_t  cmd;
  arlc_stat_t stat;
  logic       in_ready;

  assign rx_item_i.ready = in_ready;

  // Controller.
  arlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_item_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  arlc_datapath #(
    .LINE_BYTES (LINE_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .command_i    (rx_item_i.command),
    .rx_byte_i    (rx_item_i.rx_byte),
    .wait_ms_i    (rx_item_i.wait_ms),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .kind_o       (result_o.kind),
    .resp_char_o  (result_o.resp_char),
    .status_o     (result_o.status),
    .last_o       (result_o.last),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
